// File: rtl/assert_macros.svh
// Assertion macros shared by the scanner RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignore it while reset is held.
`define MSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define MSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/mss_pkg.sv
// Types and signature constants of the magic signature stream scanner.
// No dependencies.
package mss_pkg;

    localparam int NUM_TYPES = 7;

    typedef enum logic [2:0] {
        TYPE_PE      = 3'd0,
        TYPE_ELF     = 3'd1,
        TYPE_PDF     = 3'd2,
        TYPE_ZIP     = 3'd3,
        TYPE_JPEG    = 3'd4,
        TYPE_PNG     = 3'd5,
        TYPE_GZIP    = 3'd6,
        TYPE_UNKNOWN = 3'd7
    } sig_type_t;

    // Signatures right-aligned: the last byte of each sits in bits 7:0.
    localparam logic [63:0] SIG_VALUE [NUM_TYPES] = '{
        64'h0000_0000_0000_4D5A,
        64'h0000_0000_7F45_4C46,
        64'h0000_0000_2550_4446,
        64'h0000_0000_504B_0304,
        64'h0000_0000_00FF_D8FF,
        64'h8950_4E47_0D0A_1A0A,
        64'h0000_0000_0000_1F8B
    };

    localparam logic [63:0] SIG_MASK [NUM_TYPES] = '{
        64'h0000_0000_0000_FFFF,
        64'h0000_0000_FFFF_FFFF,
        64'h0000_0000_FFFF_FFFF,
        64'h0000_0000_FFFF_FFFF,
        64'h0000_0000_00FF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_FFFF
    };

    // Signature length minus one: bytes between start and current byte.
    localparam logic [2:0] SIG_SPAN [NUM_TYPES] = '{
        3'd1, 3'd3, 3'd3, 3'd3, 3'd2, 3'd7, 3'd1
    };

endpackage

// File: rtl/magic_signature_stream_scanner_core.sv
// Magic signature stream scanner: byte stream in, seven per-type reports out.
// Depends on mss_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Usage
//   Slave channel s_*: one buffer byte per request in s_tdata, s_tlast on the
//   final byte of the buffer. Every byte is scanned in the cycle it is taken;
//   a new byte can be taken every cycle unless it is a final byte held off
//   as below; a single compare-and-update stage sits behind the handshake.
//   Master channel m_*: when the final byte is taken, the statistics including
//   that byte are copied into a report buffer and the scan state returns to
//   its reset values, so the next byte starts a new buffer at offset 0.
//   The buffer then issues seven reports, one per type code 0..6, with the
//   type code in m_tuser and m_tlast on the seventh. The first report is
//   valid in the cycle after the final byte is taken.
//   Non-final bytes keep flowing while reports drain. A final byte is held
//   off (s_tready low) only while an earlier buffer still has reports
//   pending, and is taken in the cycle its last report leaves.
//   When m_tready is low the current report holds; scanning goes on.
//   Reset clears the scan state, sets the header type to unknown and drops
//   any pending reports.
module magic_signature_stream_scanner_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // end_of_buffer
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] hit_count, [32] seen, [64:33] first_start, [67:65] header_type,
    // [99:68] total_hits, [103:100] zero
    output logic [103:0] m_tdata,
    output logic [2:0]   m_tuser,   // [2:0] type_code
    output logic         m_tlast    // last_report
);
    import mss_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    // Scan state.
    logic [55:0]            window_reg;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [31:0]            cnt_reg   [NUM_TYPES];
    logic [OFFSET_BITS-1:0] first_reg [NUM_TYPES];
    logic [NUM_TYPES-1:0]   seen_reg;
    sig_type_t              hdr_reg;
    logic [31:0]            total_reg;

    // Report buffer.
    logic                   busy_reg;
    sig_type_t              idx_reg;
    logic [31:0]            snap_cnt_reg   [NUM_TYPES];
    logic [31:0]            snap_first_reg [NUM_TYPES];
    logic [NUM_TYPES-1:0]   snap_seen_reg;
    sig_type_t              snap_hdr_reg;
    logic [31:0]            snap_total_reg;

    // Updated statistics for the byte on the slave channel.
    logic [63:0]            view;
    logic [NUM_TYPES-1:0]   emb_hit;
    logic [NUM_TYPES-1:0]   hdr_hit;
    logic [31:0]            cnt_next   [NUM_TYPES];
    logic [OFFSET_BITS-1:0] first_next [NUM_TYPES];
    logic [NUM_TYPES-1:0]   seen_next;
    sig_type_t              hdr_next;
    logic [31:0]            total_next;
    logic [2:0]             emb_cnt;
    logic [32:0]            total_sum;
    logic [OFFSET_BITS-1:0] span_ext;
    logic [OFFSET_BITS-1:0] pos_next;

    logic s_fire;
    logic m_fire;
    logic rep_done;

    assign m_fire   = m_tvalid && m_tready;
    assign rep_done = m_fire && (idx_reg == TYPE_GZIP);
    // Hold off a final byte only while the report buffer is still in use.
    assign s_tready = !s_tlast || !busy_reg || rep_done;
    assign s_fire   = s_tvalid && s_tready;

    assign view = {window_reg, s_tdata};

    // Compare all seven signatures against the window and update statistics.
    always_comb
    begin
        hdr_next = hdr_reg;
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            span_ext   = {{(OFFSET_BITS-3){1'b0}}, SIG_SPAN[t]};
            hdr_hit[t] = ((view & SIG_MASK[t]) == SIG_VALUE[t]) && (pos_reg == span_ext);
            emb_hit[t] = ((view & SIG_MASK[t]) == SIG_VALUE[t]) && (pos_reg > span_ext);
            if (hdr_hit[t])
            begin
                hdr_next = sig_type_t'(3'(t));
            end
            cnt_next[t] = (emb_hit[t] && (cnt_reg[t] != 32'hFFFF_FFFF))
                        ? cnt_reg[t] + 32'd1 : cnt_reg[t];
            // Record the start offset of the first embedded match only.
            first_next[t] = (emb_hit[t] && !seen_reg[t])
                          ? pos_reg - span_ext : first_reg[t];
        end
        seen_next  = seen_reg | emb_hit;
        emb_cnt    = 3'($countones(emb_hit));
        total_sum  = {1'b0, total_reg} + {30'd0, emb_cnt};
        total_next = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
        // Saturate the byte position at all ones.
        pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + OFFSET_BITS'(1);
    end

    // Scan state: advance on every byte, return to reset after the final one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            seen_reg   <= '0;
            hdr_reg    <= TYPE_UNKNOWN;
            total_reg  <= '0;
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                cnt_reg[t]   <= '0;
                first_reg[t] <= '0;
            end
        end
        else if (s_fire)
        begin
            if (s_tlast)
            begin
                window_reg <= '0;
                pos_reg    <= '0;
                seen_reg   <= '0;
                hdr_reg    <= TYPE_UNKNOWN;
                total_reg  <= '0;
                for (int t = 0; t < NUM_TYPES; t++)
                begin
                    cnt_reg[t]   <= '0;
                    first_reg[t] <= '0;
                end
            end
            else
            begin
                window_reg <= view[55:0];
                pos_reg    <= pos_next;
                seen_reg   <= seen_next;
                hdr_reg    <= hdr_next;
                total_reg  <= total_next;
                for (int t = 0; t < NUM_TYPES; t++)
                begin
                    cnt_reg[t]   <= cnt_next[t];
                    first_reg[t] <= first_next[t];
                end
            end
        end
    end

    // Report control: load on a final byte, step one type per report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= TYPE_PE;
        end
        else if (s_fire && s_tlast)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= TYPE_PE;
        end
        else if (rep_done)
        begin
            busy_reg <= 1'b0;
        end
        else if (m_fire)
        begin
            idx_reg <= sig_type_t'(idx_reg + 3'd1);
        end
    end

    // Report payload: capture the final statistics, shift toward entry 0.
    always_ff @(posedge clk)
    begin
        if (s_fire && s_tlast)
        begin
            snap_seen_reg  <= seen_next;
            snap_hdr_reg   <= hdr_next;
            snap_total_reg <= total_next;
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                snap_cnt_reg[t]   <= cnt_next[t];
                snap_first_reg[t] <= 32'(first_next[t]);
            end
        end
        else if (m_fire)
        begin
            snap_seen_reg <= {1'b0, snap_seen_reg[NUM_TYPES-1:1]};
            for (int t = 0; t < NUM_TYPES - 1; t++)
            begin
                snap_cnt_reg[t]   <= snap_cnt_reg[t+1];
                snap_first_reg[t] <= snap_first_reg[t+1];
            end
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == TYPE_GZIP);
    assign m_tdata  = {4'd0, snap_total_reg, snap_hdr_reg, snap_first_reg[0],
                       snap_seen_reg[0], snap_cnt_reg[0]};

    `MSS_ASSERT(a_report_starts, (s_fire && s_tlast) |=> (m_tvalid && (m_tuser == TYPE_PE)),
        "report sequence did not start at the first type after a final byte")
    `MSS_ASSERT(a_report_steps, (m_fire && !m_tlast) |=> (m_tuser == 3'($past(m_tuser) + 3'd1)),
        "report type code did not advance by one")
    `MSS_ASSERT(a_report_ends, (rep_done && !(s_fire && s_tlast)) |=> !m_tvalid,
        "reports continued past the last type")
    `MSS_ASSERT(a_scan_cleared, (s_fire && s_tlast) |=> ((pos_reg == '0) && (total_reg == '0)),
        "scan state not cleared after a final byte")

endmodule

// File: bench/magic_signature_stream_scanner_core_test.sv
`timescale 1ns / 1ps
// Testbench for magic_signature_stream_scanner_core: byte buffers in, seven per-type reports out.
// Depends on mss_pkg and the scanner RTL; checks every report against its own scan predictor.

module magic_signature_stream_scanner_core_test;
    import mss_pkg::*;

    localparam int RANDOM_BYTES = 360;
    localparam int CYCLE_LIMIT  = 40000;
    localparam int HOLD_CYCLES  = 90;
    localparam int DIR_ROWS     = 25;

    // One byte request as the sender offers it.
    typedef struct {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } byte_req_t;

    // Header and total typed in by hand for a directed buffer.
    typedef struct {
        bit         typed;
        sig_type_t  header_type;
        logic [31:0] total_hits;
    } buffer_check_t;

    // Directed row: the expectation only counts on rows that end a buffer.
    typedef struct {
        logic [7:0] data_byte;
        logic       end_of_buffer;
        bit         typed;
        sig_type_t  header_type;
        logic [31:0] total_hits;
    } dir_row_t;

    typedef struct {
        sig_type_t   type_code;
        logic [31:0] hit_count;
        logic        seen;
        logic [31:0] first_start;
        sig_type_t   header_type;
        logic [31:0] total_hits;
        logic        last_report;
    } type_report_t;

    // Lone bytes that must not combine across buffers, a bare PNG header, a JPEG header
    // with PE and GZIP inside, a PDF header followed by an embedded ZIP.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h4D, 1'b1, 1'b1, TYPE_UNKNOWN, 32'd0},
        '{8'h5A, 1'b1, 1'b1, TYPE_UNKNOWN, 32'd0},
        '{8'h89, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h50, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h4E, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h47, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h0D, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h0A, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h1A, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h0A, 1'b1, 1'b1, TYPE_PNG,     32'd0},
        '{8'hFF, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'hD8, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'hFF, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h4D, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h5A, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h1F, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h8B, 1'b1, 1'b1, TYPE_JPEG,    32'd2},
        '{8'h25, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h50, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h44, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h46, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h50, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h4B, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h03, 1'b0, 1'b0, TYPE_UNKNOWN, 32'd0},
        '{8'h04, 1'b1, 1'b1, TYPE_PDF,     32'd1}
    };

    logic         clk;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    byte_req_t     byte_req_q [$];
    buffer_check_t buffer_check_q [$];
    type_report_t  report_q [$];
    logic [7:0]    pend_bytes [$];

    // Scan predictor state
    logic [55:0] scan_window;
    logic [31:0] scan_pos;
    logic [31:0] hit_counts [NUM_TYPES];
    logic [31:0] first_starts [NUM_TYPES];
    logic [6:0]  seen_mask;
    sig_type_t   header_seen;
    logic [31:0] total_count;

    int  bytes_taken  = 0;
    int  reports_seen = 0;
    int  errors       = 0;
    int  cycle_count  = 0;
    bit  calm;

    magic_signature_stream_scanner_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Quiet window: no idling on either side while these bytes go through
    assign calm = (bytes_taken >= 200) && (bytes_taken < 280);

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH report %0d %s: got %0h expected %0h", reports_seen, field, got, want);
        errors++;
    endtask

    task automatic clear_scan();
        scan_window = '0;
        scan_pos    = '0;
        seen_mask   = '0;
        header_seen = TYPE_UNKNOWN;
        total_count = '0;
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            hit_counts[t]   = '0;
            first_starts[t] = '0;
        end
    endtask

    // Advance the scan by one taken byte; on the final byte queue the seven reports.
    task automatic scan_byte(input logic [7:0] b, input logic eob);
        logic [63:0]   view;
        buffer_check_t chk;
        type_report_t  r;
        view = {scan_window, b};
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            if (scan_pos >= SIG_SPAN[t] && (view & SIG_MASK[t]) == SIG_VALUE[t])
            begin
                if (scan_pos == SIG_SPAN[t])
                    header_seen = sig_type_t'(t);
                else
                begin
                    if (!seen_mask[t])
                    begin
                        first_starts[t] = scan_pos - 32'(SIG_SPAN[t]);
                        seen_mask[t]    = 1'b1;
                    end
                    if (hit_counts[t] != '1)
                        hit_counts[t]++;
                    if (total_count != '1)
                        total_count++;
                end
            end
        end
        scan_window = view[55:0];
        if (scan_pos != '1)
            scan_pos++;
        if (eob)
        begin
            chk = buffer_check_q.pop_front();
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                r.type_code    = sig_type_t'(t);
                r.hit_count    = hit_counts[t];
                r.seen         = seen_mask[t];
                r.first_start  = seen_mask[t] ? first_starts[t] : 32'd0;
                r.header_type  = chk.typed ? chk.header_type : header_seen;
                r.total_hits   = chk.typed ? chk.total_hits : total_count;
                r.last_report  = (t == NUM_TYPES - 1);
                report_q.push_back(r);
            end
            clear_scan();
        end
    endtask

    // Append the first n bytes of a signature to the pending buffer.
    task automatic append_sig(input int t, input int n);
        for (int k = 0; k < n; k++)
            pend_bytes.push_back(SIG_VALUE[t][8 * (SIG_SPAN[t] - k) +: 8]);
    endtask

    // Random buffers: mostly well-formed signatures in random filler, some broken ones.
    task automatic build_random_buffers();
        int target;
        int len;
        int t;
        int pick;
        target = byte_req_q.size() + RANDOM_BYTES;
        while (byte_req_q.size() < target)
        begin
            pend_bytes.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(24, 4);
            pick = $urandom_range(99);
            t = $urandom_range(NUM_TYPES - 1);
            if (pick < 45)
                append_sig(t, SIG_SPAN[t] + 1);
            else if (pick < 55)
                append_sig(t, $urandom_range(SIG_SPAN[t], 1));
            while (pend_bytes.size() < len)
            begin
                pick = $urandom_range(99);
                t = $urandom_range(NUM_TYPES - 1);
                if (pick < 30)
                    append_sig(t, SIG_SPAN[t] + 1);
                else if (pick < 40)
                    append_sig(t, $urandom_range(SIG_SPAN[t], 1));
                else if (pick < 48)
                    pend_bytes.push_back($urandom_range(1) ? 8'hFF : 8'h00);
                else
                    pend_bytes.push_back(8'($urandom_range(255)));
            end
            foreach (pend_bytes[i])
                byte_req_q.push_back('{pend_bytes[i], i == pend_bytes.size() - 1});
            buffer_check_q.push_back('{1'b0, TYPE_UNKNOWN, 32'd0});
        end
    endtask

    // Offer every byte request; hold valid through back-pressure, drop it only for gaps.
    task automatic send_bytes();
        byte_req_t req;
        int        gap;
        while (byte_req_q.size() > 0)
        begin
            req = byte_req_q.pop_front();
            gap = (!calm && $urandom_range(99) < 18) ? $urandom_range(4, 1) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= req.data_byte;
            s_tlast  <= req.end_of_buffer;
            do
                @(posedge clk);
            while (!s_tready);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // Predict on every taken byte request.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            scan_byte(s_tdata, s_tlast);
            bytes_taken++;
        end
    end

    // Compare every taken report with the oldest expected one, field by field.
    always @(posedge clk)
    begin
        type_report_t got;
        type_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.type_code    = sig_type_t'(m_tuser);
            got.hit_count    = m_tdata[31:0];
            got.seen         = m_tdata[32];
            got.first_start  = m_tdata[64:33];
            got.header_type  = sig_type_t'(m_tdata[67:65]);
            got.total_hits   = m_tdata[99:68];
            got.last_report  = m_tlast;
            if (report_q.size() == 0)
                note_mismatch("unexpected report, type_code", got.type_code, 32'd0);
            else
            begin
                want = report_q.pop_front();
                if (got.type_code !== want.type_code)
                    note_mismatch("type_code", got.type_code, want.type_code);
                if (got.hit_count !== want.hit_count)
                    note_mismatch("hit_count", got.hit_count, want.hit_count);
                if (got.seen !== want.seen)
                    note_mismatch("seen", got.seen, want.seen);
                if (got.first_start !== want.first_start)
                    note_mismatch("first_start", got.first_start, want.first_start);
                if (got.header_type !== want.header_type)
                    note_mismatch("header_type", got.header_type, want.header_type);
                if (got.total_hits !== want.total_hits)
                    note_mismatch("total_hits", got.total_hits, want.total_hits);
                if (got.last_report !== want.last_report)
                    note_mismatch("last_report", got.last_report, want.last_report);
            end
            reports_seen++;
        end
    end

    // Report side: random stalls, plus one long hold-off so the pending reports
    // back up and the next final byte is held off at the input.
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && rst_n && bytes_taken >= 120)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= rst_n && (calm || $urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clear_scan();
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            byte_req_q.push_back('{dir_rows[i].data_byte, dir_rows[i].end_of_buffer});
            if (dir_rows[i].end_of_buffer)
                buffer_check_q.push_back('{dir_rows[i].typed, dir_rows[i].header_type,
                                           dir_rows[i].total_hits});
        end
        build_random_buffers();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_bytes();
        // Let the predictor take the last byte before looking at the queue.
        @(posedge clk);

        // Drain the remaining reports, then watch a little longer for strays.
        while (report_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
